[rtl/tagged_packet_queue_policy_core_defines.svh]
// Assertion macros for the tagged packet queue.
`ifndef TAGGED_PACKET_QUEUE_POLICY_CORE_DEFINES_SVH
`define TAGGED_PACKET_QUEUE_POLICY_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define TPQ_ASSERT(label, ck, rs, p) \
  label: assert property (@(posedge ck) disable iff (rs) p) \
    else $error("tpq assertion failed");
// Expression must never be true outside reset.
`define TPQ_ASSERT_NEVER(label, ck, rs, e) \
  label: assert property (@(posedge ck) disable iff (rs) !(e)) \
    else $error("tpq forbidden condition");
`else
`define TPQ_ASSERT(label, ck, rs, p)
`define TPQ_ASSERT_NEVER(label, ck, rs, e)
`endif
`endif

[rtl/tpq_pkg.sv]
`default_nettype none
package tpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int MODE_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 3;
  localparam int OCC_W    = 5;
  localparam int FLAG_W   = 3;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  // flag bits of a stored entry
  localparam int FL_NEIGH = 0;
  localparam int FL_HEAD  = 1;
  localparam int FL_ANN   = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ANN     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_POS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REM_H   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADPOS = 3'd4;

  localparam logic KIND_FREED = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] handle;
    logic [STAT_W-1:0]   status;
    logic                back;
    logic [OCC_W-1:0]    occ;
    logic                last;
  } tpq_res_t;

endpackage
`default_nettype wire

[rtl/tpq_mem.sv]
`default_nettype none
module tpq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 19
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/tpq_outreg.sv]
`default_nettype none
module tpq_outreg
  import tpq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire tpq_res_t             res_in,
  output logic                      free,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,  // handle, status, placed_at_back, occupancy
  output logic [0:0]                m_tuser,  // kind
  output logic                      m_tlast
);

  logic     valid;
  tpq_res_t res;

  assign free = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = M_TDATA_W'({res.occ, res.back, res.status, res.handle});
  assign m_tuser  = res.kind;
  assign m_tlast  = res.last;

endmodule
`default_nettype wire

[rtl/tagged_packet_queue_policy_core.sv]
// Sequence: an append passes the shift-prepare, insert and final states;
//   a neighbour header enqueue makes a count, a compaction and a shift pass.
// Passes read the entries one by one through the single read port of the
//   entry memory; a new item is taken only after the last operation ends.
// Reset: clears the entry count and the output register; the entry memory
//   is not cleared and needs no clearing pass.
`default_nettype none
`include "tagged_packet_queue_policy_core_defines.svh"
module tagged_packet_queue_policy_core
  import tpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // packet_handle, is_neighbour, is_header,
                                              // is_announce, position
  input  wire logic [MODE_W-1:0]    s_tuser,  // mode
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,  // handle, status, placed_at_back, occupancy
  output logic [0:0]                m_tuser,  // kind
  output logic                      m_tlast
);

  localparam int IW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int EW   = FLAG_W + HANDLE_BITS;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FWD    = 3'd1;  // forward pass over the entries
  localparam logic [2:0] S_POST   = 3'd2;  // decide after a forward pass
  localparam logic [2:0] S_SHPREP = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;  // move entries up by one, top down
  localparam logic [2:0] S_INS    = 3'd5;
  localparam logic [2:0] S_FREED  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  // forward pass kinds
  localparam logic [2:0] P_CNT_HDR = 3'd0;  // count what a neighbour header erases
  localparam logic [2:0] P_CMP_HDR = 3'd1;  // erase for a neighbour header
  localparam logic [2:0] P_FRAG    = 3'd2;  // find slot of a neighbour fragment
  localparam logic [2:0] P_ANN     = 3'd3;  // duplicate and first header search
  localparam logic [2:0] P_CMP_IDX = 3'd4;  // erase one index
  localparam logic [2:0] P_CMP_H   = 3'd5;  // erase by handle

  logic [2:0]             state;
  logic [2:0]             pass;
  logic [HANDLE_BITS-1:0] h_r;
  logic [FLAG_W-1:0]      fl_r;
  logic [IW-1:0]          tgt;
  logic [IW-1:0]          idx;
  logic [CW-1:0]          w;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          ecnt;
  logic                   found;
  logic                   allowed;
  logic                   have;
  logic [IW-1:0]          lastn;
  logic                   dup;
  logic                   hfound;
  logic [IW-1:0]          fh;
  logic                   back;
  logic [STAT_W-1:0]      fin_status;
  logic [HANDLE_W-1:0]    fin_handle;
  logic [OCC_W-1:0]       emit_occ;
  logic                   emit_en;

  // memory port
  logic                   we;
  logic [IW-1:0]          wa;
  logic [IW-1:0]          ra;
  logic [EW-1:0]          wd;
  logic [EW-1:0]          rdata;

  // output stage
  logic                   ofree;
  logic                   oload;
  tpq_res_t               ores;

  // unpacked input item
  logic [MODE_W-1:0]      in_mode;
  logic [HANDLE_BITS-1:0] in_h;
  logic                   in_neigh;
  logic                   in_head;
  logic                   in_ann;
  logic [POS_W-1:0]       in_pos;
  logic                   accept;
  logic                   full;

  // current entry of a forward pass
  logic [HANDLE_BITS-1:0] e_h;
  logic [FLAG_W-1:0]      e_f;
  logic                   erase;
  logic                   is_cmp;
  logic                   emit_now;
  logic                   proceed;
  logic                   last_e;
  logic                   allowed_n;

  assign in_mode  = s_tuser;
  assign in_h     = HANDLE_BITS'(s_tdata[HANDLE_W-1:0]);
  assign in_neigh = s_tdata[16];
  assign in_head  = s_tdata[17];
  assign in_ann   = s_tdata[18];
  assign in_pos   = s_tdata[22:19];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign full     = (cnt == CW'(QUEUE_DEPTH));

  assign e_h = rdata[HANDLE_BITS-1:0];
  assign e_f = rdata[EW-1:HANDLE_BITS];

  always_comb begin
    case (pass)
      P_CNT_HDR, P_CMP_HDR: erase = e_f[FL_NEIGH] && (found || e_f[FL_HEAD]);
      P_CMP_IDX:            erase = (idx == tgt);
      P_CMP_H:              erase = (e_h == h_r);
      default:              erase = 1'b0;
    endcase
  end

  assign is_cmp    = (pass == P_CMP_HDR) || (pass == P_CMP_IDX) || (pass == P_CMP_H);
  assign emit_now  = is_cmp && erase && emit_en;
  // stall the pass while a freed item cannot enter the output register
  assign proceed   = !emit_now || ofree;
  assign last_e    = (CW'(idx) == cnt - CW'(1));
  assign allowed_n = allowed || (e_f[FL_NEIGH] && e_f[FL_HEAD]);

  // read address: re-read the held entry on a stall so rdata stays put
  always_comb begin
    ra = '0;
    case (state)
      S_FWD:    ra = (proceed && !last_e) ? idx + IW'(1) : idx;
      S_SHPREP: ra = IW'(cnt - CW'(1));
      S_SHIFT:  ra = idx - IW'(1);
      default:  ra = '0;
    endcase
  end

  // write port: compaction keeps, shifts and the final insert
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata;
    case (state)
      S_FWD: begin
        if (proceed && is_cmp && !erase) begin
          we = 1'b1;
          wa = IW'(w);
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        wa = idx + IW'(1);
      end
      S_INS: begin
        we = 1'b1;
        wa = tgt;
        wd = {fl_r, h_r};
      end
      default: we = 1'b0;
    endcase
  end

  // result toward the output register
  always_comb begin
    oload       = 1'b0;
    ores.kind   = KIND_FREED;
    ores.handle = HANDLE_W'(e_h);
    ores.status = ST_OK;
    ores.back   = 1'b0;
    ores.occ    = emit_occ;
    ores.last   = 1'b0;
    case (state)
      S_FWD: oload = emit_now && ofree;
      S_FREED: begin
        oload       = ofree;
        ores.handle = HANDLE_W'(h_r);
        ores.occ    = OCC_W'(cnt);
      end
      S_FIN: begin
        oload       = ofree;
        ores.kind   = KIND_FINAL;
        ores.handle = fin_handle;
        ores.status = fin_status;
        ores.back   = back;
        ores.occ    = OCC_W'(cnt);
        ores.last   = 1'b1;
      end
      default: oload = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            h_r        <= in_h;
            fl_r       <= {in_ann, in_head, in_neigh};
            fin_handle <= '0;
            fin_status <= ST_OK;
            back       <= 1'b0;
            emit_en    <= 1'b0;
            found      <= 1'b0;
            ecnt       <= '0;
            w          <= '0;
            idx        <= '0;
            allowed    <= 1'b0;
            have       <= 1'b0;
            dup        <= 1'b0;
            hfound     <= 1'b0;
            tgt        <= '0;
            unique case (in_mode)
              MODE_ENQ: begin
                if (full) begin
                  fin_status <= ST_FULL;
                  state      <= S_FIN;
                end else if (!in_neigh || cnt == '0) begin
                  // mission packet, or nothing to scan: append
                  tgt   <= IW'(cnt);
                  back  <= !in_neigh || in_head;
                  state <= S_SHPREP;
                end else begin
                  pass  <= in_head ? P_CNT_HDR : P_FRAG;
                  state <= S_FWD;
                end
              end
              MODE_ANN: begin
                fl_r[FL_ANN] <= 1'b1;
                if (cnt == '0) begin
                  state <= S_SHPREP;
                end else begin
                  pass  <= P_ANN;
                  state <= S_FWD;
                end
              end
              MODE_DEQ: begin
                if (cnt == '0) begin
                  fin_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  pass  <= P_CMP_IDX;
                  state <= S_FWD;
                end
              end
              MODE_REM_POS: begin
                if (CMPW'(in_pos) >= CMPW'(cnt)) begin
                  fin_status <= ST_BADPOS;
                  state      <= S_FIN;
                end else begin
                  tgt      <= IW'(in_pos);
                  pass     <= P_CMP_IDX;
                  emit_en  <= 1'b1;
                  emit_occ <= OCC_W'(cnt - CW'(1));
                  state    <= S_FWD;
                end
              end
              MODE_REM_H: begin
                if (cnt == '0) begin
                  state <= S_FREED;
                end else begin
                  pass  <= P_CMP_H;
                  state <= S_FWD;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end

        S_FWD: begin
          if (proceed) begin
            if ((pass == P_CNT_HDR || pass == P_CMP_HDR) && erase && !found) begin
              found <= 1'b1;
              if (pass == P_CMP_HDR) begin
                tgt <= IW'(w);
              end
            end
            if (pass == P_CNT_HDR && erase) begin
              ecnt <= ecnt + CW'(1);
            end
            if (is_cmp && !erase) begin
              w <= w + CW'(1);
            end
            if (pass == P_CMP_IDX && erase && !emit_en) begin
              fin_handle <= HANDLE_W'(e_h);
            end
            if (pass == P_FRAG) begin
              allowed <= allowed_n;
              if (e_f[FL_NEIGH] && allowed_n) begin
                have  <= 1'b1;
                lastn <= idx;
              end
            end
            if (pass == P_ANN) begin
              if (e_f[FL_ANN]) begin
                dup <= 1'b1;
              end
              if (e_f[FL_HEAD] && !hfound) begin
                hfound <= 1'b1;
                fh     <= idx;
              end
            end
            if (last_e) begin
              state <= S_POST;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end

        S_POST: begin
          case (pass)
            P_CNT_HDR: begin
              // freed items report the count after the new header goes in
              emit_occ <= OCC_W'(cnt - ecnt + CW'(1));
              emit_en  <= 1'b1;
              found    <= 1'b0;
              w        <= '0;
              idx      <= '0;
              pass     <= P_CMP_HDR;
              state    <= S_FWD;
            end
            P_CMP_HDR: begin
              cnt <= w;
              if (!found) begin
                tgt  <= IW'(w);
                back <= 1'b1;
              end
              state <= S_SHPREP;
            end
            P_FRAG: begin
              tgt   <= have ? lastn + IW'(1) : '0;
              state <= S_SHPREP;
            end
            P_ANN: begin
              if (dup) begin
                fin_status <= ST_DUP;
                state      <= S_FREED;
              end else if (full) begin
                fin_status <= ST_FULL;
                state      <= S_FIN;
              end else begin
                tgt   <= hfound ? fh : IW'(cnt);
                back  <= !hfound;
                state <= S_SHPREP;
              end
            end
            P_CMP_H: begin
              cnt   <= w;
              state <= S_FREED;
            end
            default: begin
              cnt   <= w;
              state <= S_FIN;
            end
          endcase
        end

        S_SHPREP: begin
          if (CW'(tgt) == cnt) begin
            state <= S_INS;
          end else begin
            idx   <= IW'(cnt - CW'(1));
            state <= S_SHIFT;
          end
        end

        S_SHIFT: begin
          if (idx == tgt) begin
            state <= S_INS;
          end else begin
            idx <= idx - IW'(1);
          end
        end

        S_INS: begin
          cnt   <= cnt + CW'(1);
          state <= S_FIN;
        end

        S_FREED: begin
          if (ofree) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (ofree) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  tpq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (wd),
    .raddr (ra),
    .rdata (rdata)
  );

  tpq_outreg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (oload),
    .res_in   (ores),
    .free     (ofree),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `TPQ_ASSERT(a_cnt_range, clk, rst, cnt <= CW'(QUEUE_DEPTH))
  `TPQ_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> state != S_IDLE)
  `TPQ_ASSERT(a_cnt_hold_idle, clk, rst, state == S_IDLE && !s_tvalid |=> $stable(cnt))
  `TPQ_ASSERT_NEVER(a_last_is_final, clk, rst, m_tvalid && m_tlast && m_tuser[0] == KIND_FREED)

endmodule
`default_nettype wire
